/* src/tlpl_pkg.sv */
// Shared constants and types for the tile layer pixel lookup block.
`default_nettype none

package tlpl_pkg;

    // Store geometry defaults
    localparam int MAX_COLS_DEF = 64;
    localparam int MAX_ROWS_DEF = 64;

    // Field widths
    localparam int KIND_W    = 2;
    localparam int CELL_W    = 6;
    localparam int ENTRY_W   = 32;
    localparam int HALF_W    = 16;
    localparam int DELTA_W   = 13;
    localparam int COORD_W   = 12;
    localparam int MAPC_W    = 13;
    localparam int TILE_W    = 7;
    localparam int VIEW_W    = 13;
    localparam int MPX_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    // Packed stream widths
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 80;

    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = 32'hFFFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MAX   = 12'hFFF;

    // Register reset values
    localparam logic [TILE_W-1:0] TILE_W_RST = 7'd16;
    localparam logic [TILE_W-1:0] TILE_H_RST = 7'd16;
    localparam logic [TILE_W-1:0] COLS_RST   = 7'd64;
    localparam logic [TILE_W-1:0] ROWS_RST   = 7'd64;
    localparam logic [VIEW_W-1:0] VIEW_W_RST = 13'd320;
    localparam logic [VIEW_W-1:0] VIEW_H_RST = 13'd224;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE  = 2'd0,
        KIND_SCROLL = 2'd1,
        KIND_LOOKUP = 2'd2
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILE_WIDTH  = 3'd0,
        CFG_TILE_HEIGHT = 3'd1,
        CFG_MAP_COLS    = 3'd2,
        CFG_MAP_ROWS    = 3'd3,
        CFG_VIEW_WIDTH  = 3'd4,
        CFG_VIEW_HEIGHT = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

/* src/tile_layer_pixel_lookup.sv */
// Top level of the tile layer: map store, view scrolling and pixel lookup.
// A tile write word finishes in the idle state and gives no result; a scroll word passes
// through the multiply and clamp states; a lookup runs 13 steps of the bit-serial divider,
// a check, a store read and the hand-over, skips the store read when the pixel is off the
// view or off the map, and goes straight to the hand-over when a tile size is zero. The next
// word is accepted once the result is parked in the output register, not while one is in work.
// Reset is synchronous; the store is then swept to the empty entry, one entry per cycle over
// all MAX_COLS*MAX_ROWS entries (4096 by default), with no word accepted.
`default_nettype none

module tile_layer_pixel_lookup #(
    parameter int MAX_COLS = tlpl_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = tlpl_pkg::MAX_ROWS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Configuration write port
    input  wire logic                            i_cfg_we,
    input  wire logic [tlpl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [tlpl_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    // Input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    // cell_col[5:0], cell_row[11:6], tile_entry[43:12], scroll_dx[56:44],
    // scroll_dy[69:57], pixel_x[81:70], pixel_y[93:82], zero fill[95:94]
    input  wire logic [tlpl_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  wire logic [tlpl_pkg::KIND_W-1:0]     i_s_tuser,
    // Output stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    // source_x[15:0], source_y[31:16], hit_col[43:32], hit_row[55:44],
    // origin_x[67:56], origin_y[79:68]
    output logic      [tlpl_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // empty_flag[0]
    output logic                                 o_m_tuser
);

    localparam int DEPTH     = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIV_STEPS = tlpl_pkg::MAPC_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int LIM_W     = 9;
    localparam logic [LIM_W-1:0] COLS_LIM = LIM_W'(MAX_COLS);
    localparam logic [LIM_W-1:0] ROWS_LIM = LIM_W'(MAX_ROWS);

    // Input word offsets, lowest field first.
    localparam int OFS_COL = 0;
    localparam int OFS_ROW = OFS_COL + tlpl_pkg::CELL_W;
    localparam int OFS_ENT = OFS_ROW + tlpl_pkg::CELL_W;
    localparam int OFS_DX  = OFS_ENT + tlpl_pkg::ENTRY_W;
    localparam int OFS_DY  = OFS_DX + tlpl_pkg::DELTA_W;
    localparam int OFS_PX  = OFS_DY + tlpl_pkg::DELTA_W;
    localparam int OFS_PY  = OFS_PX + tlpl_pkg::COORD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCROLL_MUL,
        S_SCROLL_CLAMP,
        S_DIV,
        S_CHECK,
        S_FETCH,
        S_EMIT
    } t_state;

    // The result of one restoring division step.
    typedef struct packed {
        logic [tlpl_pkg::TILE_W-1:0] rem;
        logic [tlpl_pkg::MAPC_W-1:0] dvd;
    } t_div;

    // One step of the restoring divider: the top dividend bit moves into the partial
    // remainder and the quotient bit moves in at the bottom of the dividend register.
    function automatic t_div div_step(input logic [tlpl_pkg::TILE_W-1:0] rem,
                                      input logic [tlpl_pkg::MAPC_W-1:0] dvd,
                                      input logic [tlpl_pkg::TILE_W-1:0] dsr);
        logic [tlpl_pkg::TILE_W:0] trial;
        logic                      ge;
        t_div                      res;
        trial   = {rem, dvd[tlpl_pkg::MAPC_W-1]};
        ge      = (trial >= {1'b0, dsr});
        res.rem = ge ? tlpl_pkg::TILE_W'(trial - {1'b0, dsr})
                     : tlpl_pkg::TILE_W'(trial);
        res.dvd = {dvd[tlpl_pkg::MAPC_W-2:0], ge};
        return res;
    endfunction

    // Clamps one axis of the view origin so that the view stays inside the map.
    function automatic logic [tlpl_pkg::COORD_W-1:0] clamp_axis(
        input logic [tlpl_pkg::COORD_W-1:0] start,
        input logic [tlpl_pkg::DELTA_W-1:0] d,
        input logic [tlpl_pkg::VIEW_W-1:0]  size,
        input logic [tlpl_pkg::MPX_W-1:0]   map_px
    );
        logic signed [15:0] s;
        logic signed [15:0] val;
        logic signed [15:0] sz;
        logic signed [15:0] mp;
        logic signed [15:0] r;
        s   = $signed({4'b0, start});
        val = s + $signed({{3{d[tlpl_pkg::DELTA_W-1]}}, d});
        sz  = $signed({3'b0, size});
        mp  = $signed({2'b0, map_px});
        if (val < 0) begin
            r = 16'sd0;
        end else if (sz >= mp) begin
            r = s;
        end else if (val + sz >= mp) begin
            r = mp - sz;
        end else begin
            r = val;
        end
        if (r > $signed({4'b0, tlpl_pkg::COORD_MAX})) begin
            r = $signed({4'b0, tlpl_pkg::COORD_MAX});
        end
        return r[tlpl_pkg::COORD_W-1:0];
    endfunction

    // Configuration registers
    logic [tlpl_pkg::TILE_W-1:0] r_tile_w;
    logic [tlpl_pkg::TILE_W-1:0] r_tile_h;
    logic [tlpl_pkg::TILE_W-1:0] r_map_cols;
    logic [tlpl_pkg::TILE_W-1:0] r_map_rows;
    logic [tlpl_pkg::VIEW_W-1:0] r_view_w;
    logic [tlpl_pkg::VIEW_W-1:0] r_view_h;

    // Control and working state
    t_state                       r_state;
    logic                         r_clr_busy;
    logic [ADDR_W-1:0]            r_clr_addr;
    logic [tlpl_pkg::COORD_W-1:0] r_org_x;
    logic [tlpl_pkg::COORD_W-1:0] r_org_y;
    logic [tlpl_pkg::DELTA_W-1:0] r_dx;
    logic [tlpl_pkg::DELTA_W-1:0] r_dy;
    logic [tlpl_pkg::MPX_W-1:0]   r_map_px;
    logic [tlpl_pkg::MPX_W-1:0]   r_map_py;
    logic [tlpl_pkg::COORD_W-1:0] r_px;
    logic [tlpl_pkg::COORD_W-1:0] r_py;
    logic [tlpl_pkg::MAPC_W-1:0]  r_dvd_x;
    logic [tlpl_pkg::MAPC_W-1:0]  r_dvd_y;
    logic [tlpl_pkg::TILE_W-1:0]  r_rem_x;
    logic [tlpl_pkg::TILE_W-1:0]  r_rem_y;
    logic [STEP_W-1:0]            r_step;

    // Pending result, parked until the output register is free
    logic [tlpl_pkg::HALF_W-1:0]  r_sx;
    logic [tlpl_pkg::HALF_W-1:0]  r_sy;
    logic                         r_empty;
    logic [tlpl_pkg::COORD_W-1:0] r_hc;
    logic [tlpl_pkg::COORD_W-1:0] r_hr;

    // Output register
    logic                         r_out_valid;
    logic [tlpl_pkg::HALF_W-1:0]  r_out_sx;
    logic [tlpl_pkg::HALF_W-1:0]  r_out_sy;
    logic                         r_out_empty;
    logic [tlpl_pkg::COORD_W-1:0] r_out_hc;
    logic [tlpl_pkg::COORD_W-1:0] r_out_hr;
    logic [tlpl_pkg::COORD_W-1:0] r_out_ox;
    logic [tlpl_pkg::COORD_W-1:0] r_out_oy;

    // Input word fields
    tlpl_pkg::t_kind              in_kind;
    logic [tlpl_pkg::CELL_W-1:0]  in_col;
    logic [tlpl_pkg::CELL_W-1:0]  in_row;
    logic [tlpl_pkg::ENTRY_W-1:0] in_entry;
    logic [tlpl_pkg::DELTA_W-1:0] in_dx;
    logic [tlpl_pkg::DELTA_W-1:0] in_dy;
    logic [tlpl_pkg::COORD_W-1:0] in_px;
    logic [tlpl_pkg::COORD_W-1:0] in_py;
    logic                         in_accept;

    logic [tlpl_pkg::TILE_W-1:0]  eff_cols;
    logic [tlpl_pkg::TILE_W-1:0]  eff_rows;
    t_div                         step_x;
    t_div                         step_y;
    logic                         off_view;
    logic                         off_map;
    logic                         cell_in_store;
    logic                         entry_empty;

    logic                         mem_we;
    logic [ADDR_W-1:0]            mem_waddr;
    logic [tlpl_pkg::ENTRY_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]            mem_raddr;
    logic [tlpl_pkg::ENTRY_W-1:0] mem_rdata;

    assign in_kind  = tlpl_pkg::t_kind'(i_s_tuser);
    assign in_col   = i_s_tdata[OFS_COL +: tlpl_pkg::CELL_W];
    assign in_row   = i_s_tdata[OFS_ROW +: tlpl_pkg::CELL_W];
    assign in_entry = i_s_tdata[OFS_ENT +: tlpl_pkg::ENTRY_W];
    assign in_dx    = i_s_tdata[OFS_DX +: tlpl_pkg::DELTA_W];
    assign in_dy    = i_s_tdata[OFS_DY +: tlpl_pkg::DELTA_W];
    assign in_px    = i_s_tdata[OFS_PX +: tlpl_pkg::COORD_W];
    assign in_py    = i_s_tdata[OFS_PY +: tlpl_pkg::COORD_W];

    // Words are taken only in the idle state and never during the clearing sweep. A result
    // waiting in the output register does not hold the input back.
    assign o_s_tready = (r_state == S_IDLE) && !r_clr_busy;
    assign in_accept  = i_s_tvalid && o_s_tready;

    // The map in use never exceeds the store. The map registers are 7 bits wide, so when the
    // store limit is the smaller value it fits in 7 bits as well.
    assign eff_cols = ({2'b0, r_map_cols} < COLS_LIM) ? r_map_cols
                                                       : COLS_LIM[tlpl_pkg::TILE_W-1:0];
    assign eff_rows = ({2'b0, r_map_rows} < ROWS_LIM) ? r_map_rows
                                                       : ROWS_LIM[tlpl_pkg::TILE_W-1:0];

    assign step_x = div_step(r_rem_x, r_dvd_x, r_tile_w);
    assign step_y = div_step(r_rem_y, r_dvd_y, r_tile_h);

    // Checks on the pixel and on the finished quotients, used in the check state.
    assign off_view = ({1'b0, r_px} >= r_view_w) || ({1'b0, r_py} >= r_view_h);
    assign off_map  = (r_dvd_x >= {6'b0, eff_cols}) || (r_dvd_y >= {6'b0, eff_rows});

    assign cell_in_store = ({3'b0, in_col} < COLS_LIM) && ({3'b0, in_row} < ROWS_LIM);
    assign entry_empty   = (mem_rdata == tlpl_pkg::EMPTY_ENTRY);

    // The write port serves the clearing sweep first and then tile writes. The read address
    // follows the quotient registers; it is meaningful only when the cell lies on the map,
    // and the data comes back in the fetch state.
    always_comb begin
        if (r_clr_busy) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = tlpl_pkg::EMPTY_ENTRY;
        end else begin
            mem_we    = in_accept && (in_kind == tlpl_pkg::KIND_WRITE) && cell_in_store;
            mem_waddr = ADDR_W'(32'(in_row) * MAX_COLS + 32'(in_col));
            mem_wdata = in_entry;
        end
        mem_raddr = ADDR_W'(32'(r_dvd_y) * MAX_COLS + 32'(r_dvd_x));
    end

    tlpl_ram #(
        .WIDTH (tlpl_pkg::ENTRY_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    // Configuration: writes to indexes past the last register are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_w   <= tlpl_pkg::TILE_W_RST;
            r_tile_h   <= tlpl_pkg::TILE_H_RST;
            r_map_cols <= tlpl_pkg::COLS_RST;
            r_map_rows <= tlpl_pkg::ROWS_RST;
            r_view_w   <= tlpl_pkg::VIEW_W_RST;
            r_view_h   <= tlpl_pkg::VIEW_H_RST;
        end else if (i_cfg_we) begin
            case (tlpl_pkg::t_cfg_idx'(i_cfg_idx))
                tlpl_pkg::CFG_TILE_WIDTH:  r_tile_w   <= i_cfg_data[tlpl_pkg::TILE_W-1:0];
                tlpl_pkg::CFG_TILE_HEIGHT: r_tile_h   <= i_cfg_data[tlpl_pkg::TILE_W-1:0];
                tlpl_pkg::CFG_MAP_COLS:    r_map_cols <= i_cfg_data[tlpl_pkg::TILE_W-1:0];
                tlpl_pkg::CFG_MAP_ROWS:    r_map_rows <= i_cfg_data[tlpl_pkg::TILE_W-1:0];
                tlpl_pkg::CFG_VIEW_WIDTH:  r_view_w   <= i_cfg_data;
                tlpl_pkg::CFG_VIEW_HEIGHT: r_view_h   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer, view origin, clearing sweep and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end

            // In the emit state the output register is reloaded by the sequencer below.
            if (r_out_valid && i_m_tready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_dx <= in_dx;
                        r_dy <= in_dy;
                        r_px <= in_px;
                        r_py <= in_py;
                        // The dividers start on the map pixel position.
                        r_dvd_x <= {1'b0, r_org_x} + {1'b0, in_px};
                        r_dvd_y <= {1'b0, r_org_y} + {1'b0, in_py};
                        r_rem_x <= '0;
                        r_rem_y <= '0;
                        r_step  <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_hc    <= '0;
                        r_hr    <= '0;
                        r_empty <= (in_kind == tlpl_pkg::KIND_LOOKUP)
                                   && (r_tile_w == '0 || r_tile_h == '0);
                        case (in_kind)
                            tlpl_pkg::KIND_SCROLL: begin
                                r_state <= S_SCROLL_MUL;
                            end
                            tlpl_pkg::KIND_LOOKUP: begin
                                // A zero tile size has no cells: the pixel is empty
                                // and no cell is reported.
                                if (r_tile_w == '0 || r_tile_h == '0) begin
                                    r_state <= S_EMIT;
                                end else begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                // Tile writes finish here; the unused kind is dropped.
                            end
                        endcase
                    end
                end

                S_SCROLL_MUL: begin
                    r_map_px <= tlpl_pkg::MPX_W'(eff_cols) * tlpl_pkg::MPX_W'(r_tile_w);
                    r_map_py <= tlpl_pkg::MPX_W'(eff_rows) * tlpl_pkg::MPX_W'(r_tile_h);
                    r_state  <= S_SCROLL_CLAMP;
                end

                S_SCROLL_CLAMP: begin
                    r_org_x <= clamp_axis(r_org_x, r_dx, r_view_w, r_map_px);
                    r_org_y <= clamp_axis(r_org_y, r_dy, r_view_h, r_map_py);
                    r_state <= S_EMIT;
                end

                S_DIV: begin
                    r_rem_x <= step_x.rem;
                    r_dvd_x <= step_x.dvd;
                    r_rem_y <= step_y.rem;
                    r_dvd_y <= step_y.dvd;
                    r_step  <= r_step + 1'b1;
                    if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                        r_state <= S_CHECK;
                    end
                end

                S_CHECK: begin
                    // The reported cell saturates at the largest coordinate.
                    r_hc <= (r_dvd_x > {1'b0, tlpl_pkg::COORD_MAX}) ? tlpl_pkg::COORD_MAX
                                                                    : r_dvd_x[11:0];
                    r_hr <= (r_dvd_y > {1'b0, tlpl_pkg::COORD_MAX}) ? tlpl_pkg::COORD_MAX
                                                                    : r_dvd_y[11:0];
                    if (off_view || off_map) begin
                        r_empty <= 1'b1;
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_FETCH;
                    end
                end

                S_FETCH: begin
                    // Tileset position plus the offset inside the tile, wrapping at 16 bits.
                    if (entry_empty) begin
                        r_empty <= 1'b1;
                    end else begin
                        r_sx <= mem_rdata[tlpl_pkg::HALF_W-1:0] + {9'b0, r_rem_x};
                        r_sy <= mem_rdata[tlpl_pkg::ENTRY_W-1:tlpl_pkg::HALF_W]
                                + {9'b0, r_rem_y};
                    end
                    r_state <= S_EMIT;
                end

                S_EMIT: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_sx    <= r_sx;
                        r_out_sy    <= r_sy;
                        r_out_empty <= r_empty;
                        r_out_hc    <= r_hc;
                        r_out_hr    <= r_hr;
                        r_out_ox    <= r_org_x;
                        r_out_oy    <= r_org_y;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_oy, r_out_ox, r_out_hr, r_out_hc, r_out_sy, r_out_sx};
    assign o_m_tuser  = r_out_empty;

    // No word is taken while the store is still being cleared.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_clr_busy && o_s_tready))
        else $error("input word accepted during the clearing sweep");

    // The divider never runs past its last step.
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step <= STEP_W'(DIV_STEPS - 1)))
        else $error("divider step counter out of range");

    // An empty pixel carries a zero source position.
    a_empty_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> (r_out_sx == '0 && r_out_sy == '0))
        else $error("empty pixel with non-zero source position");

    // A parked result reaches the output register as soon as it is free.
    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && (!r_out_valid || i_m_tready)) |=>
            (r_out_valid && r_state == S_IDLE))
        else $error("result not moved to the output register");

endmodule

`default_nettype wire

/* src/tlpl_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module tlpl_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* tb/tb_tile_layer_pixel_lookup.sv */
// Self-checking testbench for the tile layer pixel lookup block, driven over its stream ports.
`timescale 1ns / 1ps

module tb_tile_layer_pixel_lookup;
    import tlpl_pkg::*;

    // Kind code that the block must swallow without a result.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Cycles allowed for a word still inside the block once the last awaited result is out.
    // This leaves a comfortable margin over the slowest lookup.
    localparam int SETTLE_CYCLES = 24;

    // One result word as it is expected on the output stream.
    typedef struct {
        logic [HALF_W-1:0]  source_x;
        logic [HALF_W-1:0]  source_y;
        logic               empty_flag;
        logic [COORD_W-1:0] hit_col;
        logic [COORD_W-1:0] hit_row;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
    } t_pixel_out;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx    = '0;
    logic [CFG_DAT_W-1:0] cfg_data   = '0;
    logic                 s_tvalid   = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata    = '0;
    logic [KIND_W-1:0]    s_tuser    = '0;
    logic                 m_tvalid;
    logic                 m_tready   = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    tile_layer_pixel_lookup i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the layer: tile map, view origin and registers.
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] tile_map [MAX_COLS_DEF*MAX_ROWS_DEF];
    logic [COORD_W-1:0] view_x;
    logic [COORD_W-1:0] view_y;
    logic [TILE_W-1:0]  lay_tile_w;
    logic [TILE_W-1:0]  lay_tile_h;
    logic [TILE_W-1:0]  lay_cols;
    logic [TILE_W-1:0]  lay_rows;
    logic [VIEW_W-1:0]  lay_view_w;
    logic [VIEW_W-1:0]  lay_view_h;

    // Results awaited on the output stream, oldest first.
    t_pixel_out pixels_due [$];

    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    int          rx_stall       = 0;
    int unsigned rx_roll;
    t_pixel_out  seen_word;
    t_pixel_out  want_word;

    always @(posedge clk) cycle_count <= cycle_count + 1;

    // Moves one origin axis by d and clamps it so that the view stays on the map. An
    // underflow lands on zero, and an axis whose view covers the whole map does not move.
    function automatic logic [COORD_W-1:0] clamp_origin(int start, int d, int span, int map_px);
        int moved;
        int pos;
        moved = start + d;
        if (moved < 0)
            pos = 0;
        else if (span >= map_px)
            pos = start;
        else if (moved + span >= map_px)
            pos = map_px - span;
        else
            pos = moved;
        if (pos < 0)
            pos = 0;
        if (pos > int'(COORD_MAX))
            pos = int'(COORD_MAX);
        return COORD_W'(pos);
    endfunction

    // Applies one accepted word to the shadow layer and queues the result it should give.
    task automatic step_layer(logic [KIND_W-1:0] kind, logic [CELL_W-1:0] col,
                              logic [CELL_W-1:0] row, logic [ENTRY_W-1:0] entry,
                              logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                              logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        t_pixel_out         res;
        int                 cols_used;
        int                 rows_used;
        int                 tw;
        int                 th;
        int                 mx;
        int                 my;
        int                 hit_c;
        int                 hit_r;
        logic [ENTRY_W-1:0] stored;
        res.source_x   = '0;
        res.source_y   = '0;
        res.empty_flag = 1'b0;
        res.hit_col    = '0;
        res.hit_row    = '0;
        tw        = int'(lay_tile_w);
        th        = int'(lay_tile_h);
        cols_used = (int'(lay_cols) < MAX_COLS_DEF) ? int'(lay_cols) : MAX_COLS_DEF;
        rows_used = (int'(lay_rows) < MAX_ROWS_DEF) ? int'(lay_rows) : MAX_ROWS_DEF;
        case (kind)
            KIND_WRITE: begin
                tile_map[int'(row) * MAX_COLS_DEF + int'(col)] = entry;
                return;
            end
            KIND_UNUSED: begin
                return;
            end
            KIND_SCROLL: begin
                view_x = clamp_origin(int'(view_x), int'($signed(dx)), int'(lay_view_w),
                                      cols_used * tw);
                view_y = clamp_origin(int'(view_y), int'($signed(dy)), int'(lay_view_h),
                                      rows_used * th);
            end
            default: begin
                mx = int'(view_x) + int'(px);
                my = int'(view_y) + int'(py);
                if (tw == 0 || th == 0) begin
                    res.empty_flag = 1'b1;
                end else begin
                    hit_c = mx / tw;
                    hit_r = my / th;
                    res.hit_col = (hit_c > int'(COORD_MAX)) ? COORD_MAX : COORD_W'(hit_c);
                    res.hit_row = (hit_r > int'(COORD_MAX)) ? COORD_MAX : COORD_W'(hit_r);
                    if (int'(px) >= int'(lay_view_w) || int'(py) >= int'(lay_view_h)) begin
                        // Off view: the cell under the pixel is still reported.
                        res.empty_flag = 1'b1;
                    end else if (hit_c >= cols_used || hit_r >= rows_used) begin
                        res.empty_flag = 1'b1;
                    end else begin
                        stored = tile_map[hit_r * MAX_COLS_DEF + hit_c];
                        if (stored == EMPTY_ENTRY) begin
                            res.empty_flag = 1'b1;
                        end else begin
                            // The source position wraps within 16 bits.
                            res.source_x = stored[15:0] + HALF_W'(mx % tw);
                            res.source_y = stored[31:16] + HALF_W'(my % th);
                        end
                    end
                end
            end
        endcase
        res.origin_x = view_x;
        res.origin_y = view_y;
        pixels_due.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Output side: random back-pressure and the result checker.
    // ------------------------------------------------------------------

    // The receiver runs without stalls for one stretch in four; otherwise it drops tready
    // now and then, mostly for a few cycles and sometimes for a long while.
    always @(posedge clk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= 1'b0;
        end else if (cycle_count[9:8] == 2'b11) begin
            m_tready <= 1'b1;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                rx_stall <= (rx_roll < 97) ? $urandom_range(0, 3) : $urandom_range(20, 60);
            end
        end
    end

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Every word taken from the output stream is matched against the oldest awaited result.
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (pixels_due.size() == 0) begin
                mismatch_count++;
                $error("result word 0x%0h arrived with none awaited", m_tdata);
            end else begin
                want_word = pixels_due.pop_front();
                seen_word.source_x   = m_tdata[15:0];
                seen_word.source_y   = m_tdata[31:16];
                seen_word.hit_col    = m_tdata[43:32];
                seen_word.hit_row    = m_tdata[55:44];
                seen_word.origin_x   = m_tdata[67:56];
                seen_word.origin_y   = m_tdata[79:68];
                seen_word.empty_flag = m_tuser;
                check_field("source_x", want_word.source_x, seen_word.source_x);
                check_field("source_y", want_word.source_y, seen_word.source_y);
                check_field("empty_flag", want_word.empty_flag, seen_word.empty_flag);
                check_field("hit_col", want_word.hit_col, seen_word.hit_col);
                check_field("hit_row", want_word.hit_row, seen_word.hit_row);
                check_field("origin_x", want_word.origin_x, seen_word.origin_x);
                check_field("origin_y", want_word.origin_y, seen_word.origin_y);
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Gap before the next word: none during one stretch in four, otherwise mostly short.
    function automatic int pick_gap();
        int roll;
        if (cycle_count[10:9] == 2'b01)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one word and waits for the handshake. The caller always stands just after a
    // rising edge. tvalid stays high into the next word when no gap is drawn, so it is
    // never lowered and raised within one time step.
    task automatic send_word(logic [KIND_W-1:0] kind, logic [CELL_W-1:0] col,
                             logic [CELL_W-1:0] row, logic [ENTRY_W-1:0] entry,
                             logic [DELTA_W-1:0] dx, logic [DELTA_W-1:0] dy,
                             logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {2'b00, py, px, dy, dx, entry, row, col};
        do @(posedge clk); while (!s_tready);
        step_layer(kind, col, row, entry, dx, dy, px, py);
    endtask

    // The fields a kind does not use carry random values, which the block must ignore.
    task automatic put_tile(int col, int row, logic [ENTRY_W-1:0] entry);
        send_word(KIND_WRITE, CELL_W'(col), CELL_W'(row), entry, DELTA_W'($urandom),
                  DELTA_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic scroll_by(int dx, int dy);
        send_word(KIND_SCROLL, CELL_W'($urandom), CELL_W'($urandom), $urandom,
                  DELTA_W'(dx), DELTA_W'(dy), COORD_W'($urandom), COORD_W'($urandom));
    endtask

    task automatic look_up(int px, int py);
        send_word(KIND_LOOKUP, CELL_W'($urandom), CELL_W'($urandom), $urandom,
                  DELTA_W'($urandom), DELTA_W'($urandom), COORD_W'(px), COORD_W'(py));
    endtask

    task automatic send_unused();
        send_word(KIND_UNUSED, CELL_W'($urandom), CELL_W'($urandom), $urandom,
                  DELTA_W'($urandom), DELTA_W'($urandom), COORD_W'($urandom),
                  COORD_W'($urandom));
    endtask

    // Stops the sender until every awaited result has come out, then lets a write word that
    // may still be in flight settle. Registers are only rewritten after this.
    task automatic drain_layer();
        s_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_DAT_W'(value);
        @(posedge clk);
        case (idx)
            CFG_TILE_WIDTH:  lay_tile_w = TILE_W'(value);
            CFG_TILE_HEIGHT: lay_tile_h = TILE_W'(value);
            CFG_MAP_COLS:    lay_cols   = TILE_W'(value);
            CFG_MAP_ROWS:    lay_rows   = TILE_W'(value);
            CFG_VIEW_WIDTH:  lay_view_w = VIEW_W'(value);
            CFG_VIEW_HEIGHT: lay_view_h = VIEW_W'(value);
            default: ;
        endcase
    endtask

    // Rewrites all six registers back to back; the enable drops only after the last one.
    task automatic set_layer(int tw, int th, int cols, int rows, int vw, int vh);
        write_reg(CFG_TILE_WIDTH, tw);
        write_reg(CFG_TILE_HEIGHT, th);
        write_reg(CFG_MAP_COLS, cols);
        write_reg(CFG_MAP_ROWS, rows);
        write_reg(CFG_VIEW_WIDTH, vw);
        write_reg(CFG_VIEW_HEIGHT, vh);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Register defaults and a freshly cleared map: every lookup is empty, and the scroll
    // extremes land on zero and put the view in the far corner of a 1024 by 1024 pixel map.
    task automatic test_reset_defaults();
        look_up(0, 0);
        look_up(319, 223);
        look_up(320, 0);
        look_up(0, 224);
        scroll_by(-4096, -4096);
        scroll_by(4095, 4095);
    endtask

    // Tile entries at the store corners and at the edges of the 16-bit halves. An entry
    // with only one half all ones is a real tile; the source position wraps past 65535.
    task automatic test_tile_writes();
        put_tile(0, 0, 32'h0000_0000);
        put_tile(1, 0, 32'hFFFF_FFF8);
        put_tile(2, 0, 32'hFFFF_0001);
        put_tile(3, 0, 32'h0001_FFFF);
        put_tile(63, 63, 32'h1234_5678);
        // The origin still sits at the far corner, so this lands on the last cell.
        look_up(319, 223);
        scroll_by(-4096, -4096);
        look_up(5, 7);
        look_up(31, 15);
        look_up(47, 0);
        look_up(48, 1);
        send_unused();
    endtask

    // Zero tile size, register values beyond the store, origin saturation and a view that
    // covers the whole map.
    task automatic test_layer_edges();
        drain_layer();
        set_layer(0, 16, 64, 64, 320, 224);
        look_up(3, 3);
        drain_layer();
        set_layer(127, 127, 127, 127, 1, 1);
        scroll_by(4095, 4095);
        scroll_by(100, 100);
        look_up(0, 0);
        look_up(1, 0);
        drain_layer();
        set_layer(4, 4, 2, 2, 320, 224);
        scroll_by(8, 8);
        scroll_by(-4096, -4096);
    endtask

    // One phase of random traffic under the current registers. Most words are writes
    // into the visible map and lookups inside the view, so that real tiles are hit.
    task automatic run_random_phase(int words);
        int cols_used;
        int rows_used;
        int vis_w;
        int vis_h;
        int span;
        int roll;
        int col;
        int row;
        logic [ENTRY_W-1:0] entry;
        cols_used = (int'(lay_cols) < MAX_COLS_DEF) ? int'(lay_cols) : MAX_COLS_DEF;
        rows_used = (int'(lay_rows) < MAX_ROWS_DEF) ? int'(lay_rows) : MAX_ROWS_DEF;
        vis_w = (int'(lay_view_w) < 4096) ? int'(lay_view_w) : 4096;
        vis_h = (int'(lay_view_h) < 4096) ? int'(lay_view_h) : 4096;
        span  = int'(lay_tile_w) * 3 + 1;
        scroll_by(-4096, -4096);
        repeat (words) begin
            roll = $urandom_range(0, 99);
            if (roll < 25) begin
                col = (cols_used > 0 && $urandom_range(0, 9) < 8) ?
                      $urandom_range(0, cols_used - 1) : $urandom_range(0, 63);
                row = (rows_used > 0 && $urandom_range(0, 9) < 8) ?
                      $urandom_range(0, rows_used - 1) : $urandom_range(0, 63);
                case ($urandom_range(0, 7))
                    0:       entry = EMPTY_ENTRY;
                    1:       entry = {12'hFFF, 4'($urandom), 12'hFFF, 4'($urandom)};
                    default: entry = $urandom;
                endcase
                put_tile(col, row, entry);
            end else if (roll < 40) begin
                if ($urandom_range(0, 4) == 0)
                    scroll_by($urandom, $urandom);
                else
                    scroll_by($urandom_range(0, 2 * span) - span,
                              $urandom_range(0, 2 * span) - span);
            end else if (roll < 95) begin
                if (vis_w > 0 && vis_h > 0 && $urandom_range(0, 99) < 85)
                    look_up($urandom_range(0, vis_w - 1), $urandom_range(0, vis_h - 1));
                else
                    look_up($urandom, $urandom);
            end else begin
                send_unused();
            end
        end
    endtask

    // Eight register settings, the extremes among them, each followed by random traffic.
    // Before every change the sender waits for all awaited results to come out.
    task automatic test_random_traffic();
        int cols;
        int tw;
        for (int phase = 0; phase < 8; phase++) begin
            drain_layer();
            case (phase)
                0: set_layer(16, 16, 64, 64, 320, 224);
                1: set_layer(1, 1, 64, 64, 8, 8);
                2: set_layer(64, 64, 64, 64, 4096, 4096);
                3: set_layer(7, 3, 5, 9, 20, 10);
                4: set_layer(127, 127, 127, 127, 8191, 8191);
                5: begin
                    tw   = $urandom_range(1, 64);
                    cols = $urandom_range(1, 64);
                    set_layer(tw, $urandom_range(1, 64), cols, $urandom_range(1, 64),
                              $urandom_range(1, tw * cols), $urandom_range(1, 4096));
                end
                6: set_layer($urandom_range(1, 64), $urandom_range(1, 64), 0,
                             $urandom_range(1, 64), $urandom_range(1, 64),
                             $urandom_range(1, 64));
                default: set_layer($urandom_range(1, 127), 0, $urandom_range(1, 127),
                                   $urandom_range(1, 127), $urandom_range(1, 8191),
                                   $urandom_range(1, 8191));
            endcase
            run_random_phase(235);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence and verdict.
    // ------------------------------------------------------------------
    initial begin
        foreach (tile_map[i]) tile_map[i] = EMPTY_ENTRY;
        view_x     = '0;
        view_y     = '0;
        lay_tile_w = TILE_W_RST;
        lay_tile_h = TILE_H_RST;
        lay_cols   = COLS_RST;
        lay_rows   = ROWS_RST;
        lay_view_w = VIEW_W_RST;
        lay_view_h = VIEW_H_RST;

        // Reset once; the block then clears its store and holds tready low meanwhile,
        // which the first handshake simply waits out.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_tile_writes();
        test_layer_edges();
        test_random_traffic();
        drain_layer();

        if (mismatch_count == 0 && pixels_due.size() == 0) begin
            $display("tb_tile_layer_pixel_lookup: PASS");
        end else begin
            if (pixels_due.size() != 0)
                $error("%0d results never arrived", pixels_due.size());
            $display("tb_tile_layer_pixel_lookup: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run, the store clearing sweep included.
    initial begin
        #12_000_000;
        $display("tb_tile_layer_pixel_lookup: FAIL");
        $finish;
    end

endmodule
